// File: design/tcw_pkg.sv
package tcw_pkg;

	// Screen geometry
	localparam int COLS      = 80;
	localparam int ROWS      = 25;
	localparam int CELLS     = COLS * ROWS;
	localparam int SCROLL_N  = COLS * (ROWS - 1);
	localparam int LAST_BASE = (ROWS - 1) * COLS;
	localparam int CELL_W    = $clog2(CELLS);

	// Field widths
	localparam int CMD_W  = 2;
	localparam int CH_W   = 8;
	localparam int IDX_W  = 11;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ATTR_W = 8;
	localparam int DATA_W = 16;

	typedef logic [DATA_W-1:0] tcw_cell_t;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Special characters and reset attribute
	localparam logic [CH_W-1:0]   CH_NEWLINE   = 8'h0A;
	localparam logic [CH_W-1:0]   CH_BACKSPACE = 8'h08;
	localparam logic [CH_W-1:0]   CH_BLANK     = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_BLANK,
		ST_CLEAR,
		ST_FIN
	} tcw_state_t;

endpackage

// File: design/tcw_if.sv
interface tcw_in_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CH_W-1:0]   ch;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, cmd, ch, cell_index, input ready);
	modport sink (input valid, cmd, ch, cell_index, output ready);
endinterface

interface tcw_out_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [DATA_W-1:0] read_data;
	logic              scrolled;

	modport source (output valid, cursor_col, cursor_row, read_data, scrolled, input ready);
	modport sink (input valid, cursor_col, cursor_row, read_data, scrolled, output ready);
endinterface

// File: design/text_console_writer.sv
// Text console writer: an 80x25 screen of 16-bit cells (attribute byte over
// character byte) in one block RAM, with a cursor. Requests put a character,
// clear the screen or read one cell; each request gives one response with
// the cursor and a scroll flag. An ordinary put, a newline or a backspace
// that does not scroll, an out-of-range read and an unused command are
// answered from the idle state; an in-range read goes through RAM read,
// capture and respond. A put that runs off the last row scrolls: the screen
// RAM is copied up one row at one cell per cycle through its single write
// port and the bottom row blanked. Clear writes every cell once. No request
// is taken while a sweep runs; the attribute register may be written only
// while the block is idle.
module text_console_writer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
	tcw_in_if.sink                req,
	tcw_out_if.source             rsp
);
	import tcw_pkg::*;

	tcw_state_t        state_q, state_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [CELL_W-1:0] base_q, base_d;
	logic [CELL_W-1:0] cnt_q;
	logic [ATTR_W-1:0] attr_q;
	tcw_cell_t         rd_q;
	logic              scroll_q;

	logic              o_valid_q;
	logic [COL_W-1:0]  o_col_q;
	logic [ROW_W-1:0]  o_row_q;
	tcw_cell_t         o_data_q;
	logic              o_scr_q;

	logic              out_free;
	logic              req_fire;
	logic              idx_ok;

	logic              put_we;
	logic [CH_W-1:0]   put_chr;
	logic [COL_W-1:0]  put_wcol;
	logic [COL_W-1:0]  put_col;
	logic              put_row_inc;
	logic              put_scroll;

	logic              ram_we;
	logic [CELL_W-1:0] ram_waddr;
	tcw_cell_t         ram_wdata;
	logic              ram_re;
	logic [CELL_W-1:0] ram_raddr;
	tcw_cell_t         ram_rdata;
	logic              out_load;

	assign out_free  = !o_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign idx_ok    = req.cell_index < IDX_W'(CELLS);

	// Decode a put against the current cursor
	always_comb begin
		put_we      = 1'b0;
		put_chr     = CH_BLANK;
		put_wcol    = col_q;
		put_col     = col_q;
		put_row_inc = 1'b0;
		if (req.ch == CH_NEWLINE) begin
			put_col     = '0;
			put_row_inc = 1'b1;
		end else if (req.ch == CH_BACKSPACE) begin
			if (col_q != '0) begin
				put_we   = 1'b1;
				put_wcol = col_q - 1'b1;
				put_col  = col_q - 1'b1;
			end
		end else begin
			put_we  = 1'b1;
			put_chr = req.ch;
			if (col_q == COL_W'(COLS - 1)) begin
				put_col     = '0;
				put_row_inc = 1'b1;
			end else begin
				put_col = col_q + 1'b1;
			end
		end
		put_scroll = put_row_inc && (row_q == ROW_W'(ROWS - 1));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req.cmd)
						CMD_PUT:   state_d = put_scroll ? ST_SCROLL : ST_IDLE;
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_READ:  state_d = idx_ok ? ST_READ : ST_IDLE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:   state_d = ST_FIN;
			ST_SCROLL: state_d = (cnt_q == CELL_W'(SCROLL_N)) ? ST_BLANK : ST_SCROLL;
			ST_BLANK:  state_d = (cnt_q == CELL_W'(CELLS - 1)) ? ST_FIN : ST_BLANK;
			ST_CLEAR:  state_d = (cnt_q == CELL_W'(CELLS - 1)) ? ST_FIN : ST_CLEAR;
			ST_FIN:    state_d = out_free ? ST_IDLE : ST_FIN;
			default:   state_d = ST_IDLE;
		endcase
	end

	// RAM control and response load
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {attr_q, CH_BLANK};
		ram_re    = 1'b0;
		ram_raddr = cnt_q + CELL_W'(COLS);
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req.cmd)
						CMD_PUT: begin
							ram_we    = put_we;
							ram_waddr = base_q + CELL_W'(put_wcol);
							ram_wdata = {attr_q, put_chr};
							out_load  = !put_scroll;
						end
						CMD_CLEAR: out_load = 1'b0;
						CMD_READ: begin
							ram_re    = idx_ok;
							ram_raddr = req.cell_index[CELL_W-1:0];
							out_load  = !idx_ok;
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			ST_SCROLL: begin
				ram_re    = cnt_q != CELL_W'(SCROLL_N);
				ram_we    = cnt_q != '0;
				ram_waddr = cnt_q - 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_BLANK, ST_CLEAR: ram_we = 1'b1;
			ST_FIN:             out_load = out_free;
			default:            out_load = 1'b0;
		endcase
	end

	// Cursor update
	always_comb begin
		col_d  = col_q;
		row_d  = row_q;
		base_d = base_q;
		if (req_fire) begin
			if (req.cmd == CMD_PUT) begin
				col_d = put_col;
				if (put_row_inc && !put_scroll) begin
					row_d  = row_q + 1'b1;
					base_d = base_q + CELL_W'(COLS);
				end
			end else if (req.cmd == CMD_CLEAR) begin
				col_d  = '0;
				row_d  = '0;
				base_d = '0;
			end
		end
	end

	// Control and cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			base_q    <= '0;
			attr_q    <= ATTR_RESET;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			base_q  <= base_d;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (out_load) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// Sweep counter, read capture and response payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cnt_q    <= '0;
			rd_q     <= '0;
			scroll_q <= (req.cmd == CMD_PUT) && put_scroll;
		end else begin
			case (state_q)
				ST_SCROLL: begin
					if (cnt_q != CELL_W'(SCROLL_N)) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BLANK, ST_CLEAR: cnt_q <= cnt_q + 1'b1;
				ST_READ:            rd_q  <= ram_rdata;
				default:            cnt_q <= cnt_q;
			endcase
		end
		if (out_load) begin
			o_col_q  <= col_d;
			o_row_q  <= row_d;
			o_data_q <= (state_q == ST_FIN) ? rd_q : '0;
			o_scr_q  <= (state_q == ST_FIN) && scroll_q;
		end
	end

	assign rsp.valid      = o_valid_q;
	assign rsp.cursor_col = o_col_q;
	assign rsp.cursor_row = o_row_q;
	assign rsp.read_data  = o_data_q;
	assign rsp.scrolled   = o_scr_q;

	// Screen store
	tcw_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// File: design/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/tcw_checker.sv
module tcw_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [tcw_pkg::COL_W-1:0]  cursor_col,
	input logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	input logic [tcw_pkg::DATA_W-1:0] read_data,
	input logic                       scrolled
);
	import tcw_pkg::*;

	logic req_fire;
	logic rsp_fire;
	logic pend_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// Track the one request in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (req_fire) begin
			pend_q <= 1'b1;
		end else if (rsp_fire) begin
			pend_q <= 1'b0;
		end
	end

	// A stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_col)
			&& $stable(cursor_row) && $stable(read_data) && $stable(scrolled))
		else $error("response changed while stalled");

	// No response without a request
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q)
		else $error("response without request");

	// No second request while the first is undelivered
	assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> !pend_q || rsp_fire)
		else $error("request taken with a response outstanding");

	// Cursor stays on screen
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (cursor_col < COL_W'(COLS)) && (cursor_row < ROW_W'(ROWS)))
		else $error("cursor off screen");

	// A scroll leaves the cursor on the bottom row
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && scrolled |-> cursor_row == ROW_W'(ROWS - 1))
		else $error("scroll without cursor on bottom row");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.cursor_col (rsp.cursor_col),
	.cursor_row (rsp.cursor_row),
	.read_data  (rsp.read_data),
	.scrolled   (rsp.scrolled)
);

// File: verif/text_console_writer_test.sv
`timescale 1ns / 100ps

module text_console_writer_test;
	import tcw_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 8_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 100;
	localparam int IDX_TOP = (1 << IDX_W) - 1;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [CH_W-1:0]  ch;
		logic [IDX_W-1:0] cell_index;
	} console_req_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [DATA_W-1:0] read_data;
		logic              scrolled;
	} console_rsp_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ATTR_W-1:0] cfg_wdata;

	tcw_in_if  req_ch ();
	tcw_out_if rsp_ch ();

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Requests waiting to be offered, responses waiting to arrive
	console_req_t req_backlog[$];
	console_rsp_t rsp_owed[$];

	// Shadow copy of the console
	tcw_cell_t         shadow_screen [CELLS];
	int                shadow_col;
	int                shadow_row;
	logic [ATTR_W-1:0] shadow_attr;

	int          src_idle_pct;
	int          snk_idle_pct;
	int          hold_asked  = 0;
	int          hold_served = 0;
	int          hold_left   = 0;
	logic        req_fire    = 1'b0;
	bit          offering    = 1'b0;
	int          mismatches  = 0;
	int unsigned cycles      = 0;

	// Apply one request to the shadow console and return the response it owes
	function automatic console_rsp_t console_apply(console_req_t r);
		console_rsp_t res;
		int k;
		res = '0;
		case (r.cmd)
			CMD_PUT: begin
				if (r.ch == CH_NEWLINE) begin
					shadow_col = 0;
					shadow_row++;
				end else if (r.ch == CH_BACKSPACE) begin
					if (shadow_col > 0) begin
						shadow_col--;
						shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, CH_BLANK};
					end
				end else begin
					shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, r.ch};
					shadow_col++;
				end
				if (shadow_col >= COLS) begin
					shadow_col = 0;
					shadow_row++;
				end
				// run off the bottom: shift everything up a row, blank the last one
				if (shadow_row >= ROWS) begin
					for (k = 0; k < SCROLL_N; k++)
						shadow_screen[k] = shadow_screen[k + COLS];
					for (k = LAST_BASE; k < CELLS; k++)
						shadow_screen[k] = {shadow_attr, CH_BLANK};
					shadow_row = ROWS - 1;
					res.scrolled = 1'b1;
				end
			end
			CMD_CLEAR: begin
				for (k = 0; k < CELLS; k++)
					shadow_screen[k] = {shadow_attr, CH_BLANK};
				shadow_col = 0;
				shadow_row = 0;
			end
			CMD_READ: begin
				if (r.cell_index < CELLS)
					res.read_data = shadow_screen[r.cell_index];
			end
			default: ;
		endcase
		res.cursor_col = shadow_col[COL_W-1:0];
		res.cursor_row = shadow_row[ROW_W-1:0];
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	function automatic void queue_item(logic [CMD_W-1:0] op, logic [CH_W-1:0] c,
			logic [IDX_W-1:0] i);
		console_req_t r;
		r.cmd = op;
		r.ch = c;
		r.cell_index = i;
		req_backlog.push_back(r);
	endfunction

	// Mostly lines of text, some long enough to wrap, mixed with reads and odd requests
	task automatic queue_traffic(int n);
		int made;
		int len;
		int k;
		int pick;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(COLS - 10, 2 * COLS);
				else
					len = $urandom_range(12);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(9) == 0)
						queue_item(CMD_PUT, CH_BACKSPACE, IDX_W'($urandom_range(IDX_TOP)));
					else
						queue_item(CMD_PUT, CH_W'($urandom_range(255)),
							IDX_W'($urandom_range(IDX_TOP)));
				end
				if ($urandom_range(3) != 0)
					queue_item(CMD_PUT, CH_NEWLINE, IDX_W'($urandom_range(IDX_TOP)));
				made += len + 1;
			end else if (pick < 85) begin
				if ($urandom_range(4) == 0)
					queue_item(CMD_READ, CH_W'($urandom_range(255)),
						IDX_W'($urandom_range(IDX_TOP)));
				else
					queue_item(CMD_READ, CH_W'($urandom_range(255)),
						IDX_W'($urandom_range(CELLS - 1)));
				made++;
			end else if (pick < 87) begin
				queue_item(CMD_CLEAR, CH_W'($urandom_range(255)),
					IDX_W'($urandom_range(IDX_TOP)));
				made++;
			end else if (pick < 92) begin
				queue_item(CMD_UNUSED, CH_W'($urandom_range(255)),
					IDX_W'($urandom_range(IDX_TOP)));
				made++;
			end else begin
				queue_item(CMD_PUT, CH_W'($urandom_range(255)),
					IDX_W'($urandom_range(IDX_TOP)));
				made++;
			end
		end
	endtask

	// Wait until every request has gone in and every response has come back
	task automatic drain();
		@(negedge clk);
		while (req_backlog.size() != 0 || rsp_owed.size() != 0 || offering)
			@(negedge clk);
	endtask

	task automatic write_attr(logic [ATTR_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		shadow_attr = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Predict on each accepted request, then check each accepted response
	always @(posedge clk) begin
		console_rsp_t want;
		req_fire <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready)
			rsp_owed.push_back(console_apply({req_ch.cmd, req_ch.ch, req_ch.cell_index}));
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_owed.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: response expected none, got col %0d row %0d data 0x%0h",
						$time, rsp_ch.cursor_col, rsp_ch.cursor_row, rsp_ch.read_data);
			end else begin
				want = rsp_owed.pop_front();
				check_field("cursor_col", 32'(want.cursor_col), 32'(rsp_ch.cursor_col));
				check_field("cursor_row", 32'(want.cursor_row), 32'(rsp_ch.cursor_row));
				check_field("read_data", 32'(want.read_data), 32'(rsp_ch.read_data));
				check_field("scrolled", 32'(want.scrolled), 32'(rsp_ch.scrolled));
			end
		end
	end

	// Offer the next request at the falling edge once the last one is taken
	always @(negedge clk) begin
		console_req_t nxt;
		if (arst_n && (!req_ch.valid || req_fire)) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = req_backlog.pop_front();
				offering = 1'b1;
				req_ch.valid      <= 1'b1;
				req_ch.cmd        <= nxt.cmd;
				req_ch.ch         <= nxt.ch;
				req_ch.cell_index <= nxt.cell_index;
			end else begin
				offering = 1'b0;
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Stall responses at random, or hold off for a long stretch when asked
	always @(negedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Give up if the run hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int lap;
		int k;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_PUT;
		req_ch.ch         = '0;
		req_ch.cell_index = '0;
		rsp_ch.ready      = 1'b0;
		for (k = 0; k < CELLS; k++)
			shadow_screen[k] = '0;
		shadow_col   = 0;
		shadow_row   = 0;
		shadow_attr  = ATTR_RESET;
		src_idle_pct = 24;
		snk_idle_pct = 73;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: clear first, range edges of reads, special characters, unused code
		queue_item(CMD_CLEAR, 8'h00, 11'd0);
		queue_item(CMD_READ, 8'h00, 11'd0);
		queue_item(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
		queue_item(CMD_READ, 8'hFF, IDX_W'(IDX_TOP));
		queue_item(CMD_READ, 8'h00, IDX_W'(CELLS));
		queue_item(CMD_PUT, CH_BACKSPACE, 11'd0);
		queue_item(CMD_PUT, 8'h41, 11'd0);
		queue_item(CMD_PUT, 8'h00, IDX_W'(IDX_TOP));
		queue_item(CMD_PUT, 8'hFF, 11'd0);
		queue_item(CMD_READ, 8'h00, 11'd0);
		queue_item(CMD_READ, 8'h00, 11'd2);
		queue_item(CMD_PUT, CH_BACKSPACE, 11'd0);
		queue_item(CMD_READ, 8'h00, 11'd2);
		queue_item(CMD_PUT, CH_NEWLINE, 11'd0);
		queue_item(CMD_UNUSED, 8'hFF, IDX_W'(IDX_TOP));
		queue_item(CMD_READ, 8'h00, 11'd1);
		queue_item(CMD_PUT, 8'h7F, 11'd0);
		queue_item(CMD_PUT, 8'h80, 11'd0);
		queue_item(CMD_PUT, CH_NEWLINE, 11'd0);
		queue_item(CMD_PUT, CH_BACKSPACE, 11'd0);
		queue_item(CMD_READ, 8'h00, IDX_W'(COLS));
		queue_item(CMD_READ, 8'h00, IDX_W'(COLS + 1));
		queue_item(CMD_CLEAR, 8'hFF, IDX_W'(IDX_TOP));
		queue_item(CMD_READ, 8'h00, 11'd0);
		drain();

		// Random laps, each with its own attribute; the idling pattern changes at laps 2 and 4
		for (lap = 0; lap < 6; lap++) begin
			if (lap == 2) begin
				src_idle_pct = 73;
				snk_idle_pct = 24;
			end else if (lap == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			case (lap)
				0: write_attr(8'hFF);
				1: write_attr(8'h00);
				3: write_attr(8'h80);
				default: write_attr(ATTR_W'($urandom_range(255)));
			endcase
			if (lap == 3) begin
				// pause the sender until the block has answered everything
				queue_traffic(50);
				drain();
				queue_traffic(50);
			end else begin
				queue_traffic(100);
			end
			// hold responses back while requests keep coming
			if (lap == 4)
				hold_asked++;
			drain();
		end

		repeat (50) @(negedge clk);
		if (mismatches == 0 && rsp_owed.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
